>>> rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is high
`define SPA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// clocked check that also holds during reset
`define SPA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

>>> rtl/spa_pkg.sv
package spa_pkg;

   localparam int unsigned CHUNK_BYTES = 4096;
   localparam logic [15:0] POOL_LIMIT  = 16'd4088;
   localparam logic [3:0]  MIN_LOG2    = 4'd5;
   localparam logic [3:0]  MAX_LOG2    = 4'd12;
   localparam logic [2:0]  BOOT_K      = 3'd2;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TOO_LARGE = 2'd1,
      ST_OOM       = 2'd2,
      ST_BAD_FREE  = 2'd3
   } status_type;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_DECODE = 7'b0000100,
      S_ALLOC  = 7'b0001000,
      S_POP    = 7'b0010000,
      S_FTAG   = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   // bit length of size+7, never below the 32-byte class
   function automatic logic [3:0] class_of(input logic [12:0] v);
      logic [3:0] n;
      n = MIN_LOG2;
      for (int i = 5; i < 13; i++) begin
         if (v[i]) begin
            n = 4'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

>>> rtl/spa_ram.sv
module spa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> rtl/spa_alu.sv
module spa_alu
   import spa_pkg::*;
#(
   parameter int W = 16
) (
   input  alu_op_type   op,
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   output logic [W-1:0] y
);

   always_comb begin
      case (op)
         ALU_ADD: y = a + b;
         ALU_SUB: y = a - b;
         default: y = a;
      endcase
   end

endmodule

>>> rtl/segregated_pool_allocator_core.sv
// an allocate passes decode, alloc and done, plus a pop state when popping a
// freed block; a free passes decode, ftag and done; too_large and malformed
// free addresses go from decode to done; one request is in flight, and the
// steps are set by the shared adder and the registered tag and link reads
// reset: synchronous; afterwards the tag memory is cleared one entry a cycle,
// HEAP_BYTES/32 entries in all, with req_stall high until the sweep is done
`include "assert_macros.svh"

module segregated_pool_allocator_core
   import spa_pkg::*;
#(
   parameter int HEAP_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [15:0] req_request_size,
   input  logic [15:0] req_free_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_address,
   output logic [3:0]  rsp_class_bytes_log2,
   output logic [1:0]  rsp_status
);

   localparam int GRANULES = HEAP_BYTES / 32;
   localparam int CHUNKS   = HEAP_BYTES / CHUNK_BYTES;
   localparam int GW       = $clog2(GRANULES);
   localparam int CUW      = $clog2(CHUNKS + 1);
   localparam int AW       = (GW > 16) ? GW : 16;

   function automatic logic [15:0] addr_of(input logic [GW-1:0] g);
      return 16'({g, 5'd8});
   endfunction

   state_type      state_ff, state_in;
   logic           op_ff, op_in;
   logic [15:0]    size_ff, size_in;
   logic [15:0]    faddr_ff, faddr_in;
   logic [3:0]     cls_ff, cls_in;
   logic [GW-1:0]  gran_ff, gran_in;
   logic [GW-1:0]  clr_ff, clr_in;
   logic [GW-1:0]  head_ff [8];
   logic [GW-1:0]  head_in [8];
   logic [GW-1:0]  cursor_ff [8];
   logic [GW-1:0]  cursor_in [8];
   logic [CUW-1:0] chunks_ff, chunks_in;
   logic           boot_ff, boot_in;
   logic [15:0]    res_addr_ff, res_addr_in;
   logic [3:0]     res_cls_ff, res_cls_in;
   status_type     res_status_ff, res_status_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [15:0]    rsp_address_ff, rsp_address_in;
   logic [3:0]     rsp_class_ff, rsp_class_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;

   alu_op_type     alu_op;
   logic [AW-1:0]  alu_a, alu_b, alu_y;

   logic           tag_we, tag_re;
   logic [GW-1:0]  tag_wa, tag_ra;
   logic [3:0]     tag_wd, tag_rd;
   logic           link_we, link_re;
   logic [GW-1:0]  link_wa, link_ra;
   logic [GW-1:0]  link_wd, link_rd;

   logic [2:0]     kidx, fk;
   logic [GW-1:0]  sel_g, step, nxt;
   logic [15:0]    blk;
   logic           free_ok, have_blk;

   spa_alu #(.W(AW)) u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .y  (alu_y)
   );

   spa_ram #(.WIDTH(4), .DEPTH(GRANULES)) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (tag_wa),
      .wr_data (tag_wd),
      .rd_en   (tag_re),
      .rd_addr (tag_ra),
      .rd_data (tag_rd)
   );

   spa_ram #(.WIDTH(GW), .DEPTH(GRANULES)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_en   (link_re),
      .rd_addr (link_ra),
      .rd_data (link_rd)
   );

   assign req_stall            = (state_ff != S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_address          = rsp_address_ff;
   assign rsp_class_bytes_log2 = rsp_class_ff;
   assign rsp_status           = rsp_status_ff;

   assign kidx = 3'(cls_ff - MIN_LOG2);
   assign fk   = 3'(tag_rd - MIN_LOG2);
   assign step = GW'(1) << kidx;
   assign blk  = alu_y[15:0];
   assign nxt  = (alu_y[6:0] == 7'd0) ? '0 : GW'(alu_y);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      size_in       = size_ff;
      faddr_in      = faddr_ff;
      cls_in        = cls_ff;
      gran_in       = gran_ff;
      clr_in        = clr_ff;
      head_in       = head_ff;
      cursor_in     = cursor_ff;
      chunks_in     = chunks_ff;
      boot_in       = boot_ff;
      res_addr_in   = res_addr_ff;
      res_cls_in    = res_cls_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_address_in = rsp_address_ff;
      rsp_class_in  = rsp_class_ff;
      rsp_status_in = rsp_status_ff;
      alu_op        = ALU_ADD;
      alu_a         = '0;
      alu_b         = '0;
      tag_we        = 1'b0;
      tag_wa        = gran_ff;
      tag_wd        = cls_ff;
      tag_re        = 1'b0;
      tag_ra        = gran_ff;
      link_we       = 1'b0;
      link_wa       = gran_ff;
      link_wd       = '0;
      link_re       = 1'b0;
      link_ra       = gran_ff;
      sel_g         = '0;
      free_ok       = 1'b0;
      have_blk      = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            tag_we = 1'b1;
            tag_wa = clr_ff;
            tag_wd = '0;
            clr_in = clr_ff + GW'(1);
            if (clr_ff == GW'(GRANULES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               size_in  = req_request_size;
               faddr_in = req_free_address;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_addr_in = '0;
            res_cls_in  = '0;
            if (op_ff == OP_ALLOC) begin
               alu_op = ALU_ADD;
               alu_a  = AW'(size_ff);
               alu_b  = AW'(7);
               if (size_ff > POOL_LIMIT) begin
                  res_status_in = ST_TOO_LARGE;
                  state_in      = S_DONE;
               end else begin
                  cls_in = class_of(alu_y[12:0]);
                  if (!boot_ff) begin
                     // chunk 0 goes to the 128-byte class, its first block reserved
                     boot_in           = 1'b1;
                     chunks_in         = CUW'(1);
                     cursor_in[BOOT_K] = GW'(4);
                  end
                  state_in = S_ALLOC;
               end
            end else begin
               alu_op  = ALU_SUB;
               alu_a   = AW'(faddr_ff);
               alu_b   = AW'(8);
               free_ok = (faddr_ff >= 16'd8) && (blk[4:0] == 5'd0) &&
                         (32'(blk >> 5) < GRANULES);
               gran_in = GW'(blk >> 5);
               tag_re  = 1'b1;
               tag_ra  = GW'(blk >> 5);
               if (free_ok) begin
                  state_in = S_FTAG;
               end else begin
                  res_status_in = ST_BAD_FREE;
                  state_in      = S_DONE;
               end
            end
         end
         S_ALLOC: begin
            if (head_ff[kidx] != '0) begin
               gran_in  = head_ff[kidx];
               link_re  = 1'b1;
               link_ra  = head_ff[kidx];
               state_in = S_POP;
            end else begin
               if (cursor_ff[kidx] != '0) begin
                  sel_g    = cursor_ff[kidx];
                  have_blk = 1'b1;
               end else if (chunks_ff < CUW'(CHUNKS)) begin
                  sel_g     = GW'({chunks_ff, 7'd0});
                  chunks_in = chunks_ff + CUW'(1);
                  have_blk  = 1'b1;
               end
               alu_op = ALU_ADD;
               alu_a  = AW'(sel_g);
               alu_b  = AW'(step);
               if (have_blk) begin
                  cursor_in[kidx] = nxt;
                  tag_we          = 1'b1;
                  tag_wa          = sel_g;
                  tag_wd          = cls_ff;
                  res_addr_in     = addr_of(sel_g);
                  res_cls_in      = cls_ff;
                  res_status_in   = ST_OK;
               end else begin
                  res_status_in = ST_OOM;
               end
               state_in = S_DONE;
            end
         end
         S_POP: begin
            head_in[kidx] = link_rd;
            tag_we        = 1'b1;
            tag_wa        = gran_ff;
            tag_wd        = cls_ff;
            res_addr_in   = addr_of(gran_ff);
            res_cls_in    = cls_ff;
            res_status_in = ST_OK;
            state_in      = S_DONE;
         end
         S_FTAG: begin
            if (tag_rd >= MIN_LOG2 && tag_rd <= MAX_LOG2) begin
               tag_we        = 1'b1;
               tag_wa        = gran_ff;
               tag_wd        = '0;
               link_we       = 1'b1;
               link_wa       = gran_ff;
               link_wd       = head_ff[fk];
               head_in[fk]   = gran_ff;
               res_cls_in    = tag_rd;
               res_status_in = ST_OK;
            end else begin
               res_status_in = ST_BAD_FREE;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            // hand over once the output register is free or draining
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_address_in = res_addr_ff;
               rsp_class_in   = res_cls_ff;
               rsp_status_in  = res_status_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         chunks_ff    <= '0;
         boot_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            head_ff[i]   <= '0;
            cursor_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         chunks_ff    <= chunks_in;
         boot_ff      <= boot_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         cursor_ff    <= cursor_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      size_ff        <= size_in;
      faddr_ff       <= faddr_in;
      cls_ff         <= cls_in;
      gran_ff        <= gran_in;
      res_addr_ff    <= res_addr_in;
      res_cls_ff     <= res_cls_in;
      res_status_ff  <= res_status_in;
      rsp_address_ff <= rsp_address_in;
      rsp_class_ff   <= rsp_class_in;
      rsp_status_ff  <= rsp_status_in;
   end

   `SPA_ASSERT(a_accept_decodes, (req_valid && !req_stall) |=> (state_ff == S_DECODE), "accepted beat did not reach decode")
   `SPA_ASSERT(a_error_no_class, (rsp_valid && rsp_status != ST_OK) |-> (rsp_class_bytes_log2 == 4'd0 && rsp_address == 16'd0), "error response carries a class or address")
   `SPA_ASSERT(a_addr_aligned, (rsp_valid && rsp_address != 16'd0) |-> (rsp_address[4:0] == 5'd8 && rsp_status == ST_OK), "allocated payload address misaligned")
   `SPA_ASSERT(a_chunks_bound, chunks_ff <= CUW'(CHUNKS), "chunk count beyond heap")
   `SPA_ASSERT_ALWAYS(a_clear_blocks, (state_ff == S_CLEAR) |-> req_stall, "request taken during tag clear")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import spa_pkg::*;

   localparam int HEAP       = 65536;
   localparam int CHUNKS     = HEAP / CHUNK_BYTES;
   localparam int GRANULES   = HEAP / 32;
   localparam int HDR_BYTES  = 8;
   localparam int BOOT_CLASS = MIN_LOG2 + BOOT_K;

   typedef struct {
      opcode_type  op;
      logic [15:0] size;
      logic [15:0] faddr;
   } pool_req_t;

   typedef struct {
      logic [15:0] address;
      logic [3:0]  cls_log2;
      status_type  status;
   } pool_rsp_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_opcode = OP_ALLOC;
   logic [15:0] req_request_size = '0;
   logic [15:0] req_free_address = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_address;
   logic [3:0]  rsp_class_bytes_log2;
   logic [1:0]  rsp_status;

   segregated_pool_allocator_core #(.HEAP_BYTES(HEAP)) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_opcode           (req_opcode),
      .req_request_size     (req_request_size),
      .req_free_address     (req_free_address),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_address          (rsp_address),
      .rsp_class_bytes_log2 (rsp_class_bytes_log2),
      .rsp_status           (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // allocator shadow: granule indexes, 0 means empty / end of list
   logic [10:0] class_head   [8]        = '{default: '0};
   logic [10:0] carve_cursor [8]        = '{default: '0};
   logic [10:0] block_link   [GRANULES] = '{default: '0};
   logic [3:0]  block_tag    [GRANULES] = '{default: '0};
   int unsigned chunks_used = 0;
   bit          booted = 1'b0;

   pool_req_t   pending_requests[$];
   pool_rsp_t   pending_results[$];
   logic [15:0] live_addrs[$];
   int unsigned accepted_count = 0;
   int unsigned fail_count = 0;
   bit          steady = 1'b0;
   logic        rsp_hold = 1'b0;

   pool_req_t   drv_item;
   pool_rsp_t   drv_rsp;
   pool_rsp_t   mon_exp;

   function automatic int unsigned class_for_size(input logic [15:0] size);
      int unsigned v;
      int unsigned n;
      v = size + 7;
      n = 0;
      while (v != 0) begin
         n++;
         v >>= 1;
      end
      return (n < MIN_LOG2) ? MIN_LOG2 : n;
   endfunction

   function automatic void advance_cursor(input int unsigned cls, input int unsigned blk);
      int unsigned nxt;
      nxt = blk + (1 << cls);
      if (nxt % CHUNK_BYTES == 0) begin
         carve_cursor[cls - MIN_LOG2] = '0;
      end else begin
         carve_cursor[cls - MIN_LOG2] = 11'(nxt / 32);
      end
   endfunction

   function automatic pool_rsp_t predict_request(input pool_req_t rq);
      pool_rsp_t   r;
      int unsigned cls;
      int unsigned k;
      int unsigned blk;
      int unsigned g;
      bit          got;
      r.address  = '0;
      r.cls_log2 = '0;
      r.status   = ST_OK;
      got = 1'b0;
      blk = 0;
      if (rq.op == OP_ALLOC) begin
         if (rq.size > POOL_LIMIT) begin
            r.status = ST_TOO_LARGE;
         end else begin
            if (!booted) begin
               // chunk 0 belongs to the 128-byte class, its first block is the table
               booted = 1'b1;
               chunks_used = 1;
               advance_cursor(BOOT_CLASS, 0);
            end
            cls = class_for_size(rq.size);
            k = cls - MIN_LOG2;
            if (class_head[k] != 0) begin
               g = class_head[k];
               class_head[k] = block_link[g];
               blk = g * 32;
               got = 1'b1;
            end else if (carve_cursor[k] != 0) begin
               blk = carve_cursor[k] * 32;
               advance_cursor(cls, blk);
               got = 1'b1;
            end else if (chunks_used < CHUNKS) begin
               blk = chunks_used * CHUNK_BYTES;
               chunks_used++;
               advance_cursor(cls, blk);
               got = 1'b1;
            end
            if (got) begin
               block_tag[blk / 32] = 4'(cls);
               r.address  = 16'(blk + HDR_BYTES);
               r.cls_log2 = 4'(cls);
            end else begin
               r.status = ST_OOM;
            end
         end
      end else begin
         r.status = ST_BAD_FREE;
         if (rq.faddr >= HDR_BYTES) begin
            blk = rq.faddr - HDR_BYTES;
            g = blk / 32;
            if (blk % 32 == 0 && g < GRANULES && block_tag[g] >= MIN_LOG2
                  && block_tag[g] <= MAX_LOG2) begin
               cls = block_tag[g];
               k = cls - MIN_LOG2;
               block_tag[g] = '0;
               block_link[g] = class_head[k];
               class_head[k] = 11'(g);
               r.cls_log2 = 4'(cls);
               r.status = ST_OK;
            end
         end
      end
      return r;
   endfunction

   // driver: predicts each accepted beat and presents the next pending request
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            drv_rsp = predict_request(drv_item);
            pending_results.push_back(drv_rsp);
            accepted_count++;
            if (drv_rsp.status == ST_OK) begin
               if (drv_item.op == OP_ALLOC) begin
                  live_addrs.push_back(drv_rsp.address);
               end else begin
                  for (int i = 0; i < live_addrs.size(); i++) begin
                     if (live_addrs[i] == drv_item.faddr) begin
                        live_addrs.delete(i);
                        break;
                     end
                  end
               end
            end
         end
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() != 0 && (steady || $urandom_range(99) >= 7)) begin
               drv_item = pending_requests.pop_front();
               req_valid        <= 1'b1;
               req_opcode       <= drv_item.op;
               req_request_size <= drv_item.size;
               req_free_address <= drv_item.faddr;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each result beat against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= rsp_hold || (!steady && $urandom_range(99) < 7);
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("result beat with nothing pending");
               fail_count++;
            end else begin
               mon_exp = pending_results.pop_front();
               if (rsp_address !== mon_exp.address) begin
                  $error("rsp_address: expected %0d, got %0d", mon_exp.address, rsp_address);
                  fail_count++;
               end
               if (rsp_class_bytes_log2 !== mon_exp.cls_log2) begin
                  $error("rsp_class_bytes_log2: expected %0d, got %0d",
                         mon_exp.cls_log2, rsp_class_bytes_log2);
                  fail_count++;
               end
               if (rsp_status !== mon_exp.status) begin
                  $error("rsp_status: expected %0d, got %0d", mon_exp.status, rsp_status);
                  fail_count++;
               end
            end
         end
      end
   end

   // long receiver hold-off so the block backs up into its input
   initial begin
      wait (accepted_count >= 400);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (300) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #3ms;
      $display("TEST FAILED");
      $finish;
   end

   task automatic queue_alloc(input logic [15:0] size);
      pool_req_t rq;
      while (pending_requests.size() >= 2) @(negedge clock);
      rq.op    = OP_ALLOC;
      rq.size  = size;
      rq.faddr = 16'($urandom_range(65535));
      pending_requests.push_back(rq);
   endtask

   task automatic queue_free(input logic [15:0] addr);
      pool_req_t rq;
      while (pending_requests.size() >= 2) @(negedge clock);
      rq.op    = OP_FREE;
      rq.size  = 16'($urandom_range(65535));
      rq.faddr = addr;
      pending_requests.push_back(rq);
   endtask

   task automatic drain_results();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || pending_results.size() != 0);
   endtask

   initial begin
      int unsigned pick;
      int unsigned free_pct;
      int unsigned cls;
      int unsigned lo;
      int unsigned hi;
      logic [15:0] big_addr;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // table block before any allocate, then class boundaries
      queue_free(16'd8);
      queue_alloc(16'd0);
      queue_alloc(16'd8);
      queue_alloc(16'd9);
      queue_alloc(16'd24);
      queue_alloc(16'd25);
      queue_alloc(16'd120);
      queue_alloc(16'd121);
      queue_alloc(16'd4088);
      drain_results();

      big_addr = live_addrs[$];
      queue_free(big_addr);
      queue_free(big_addr);           // double free
      queue_free(big_addr + 16'd1);   // misaligned
      queue_free(16'd0);
      queue_free(16'd7);
      queue_free(16'd8);              // table block after bootstrap
      queue_free(16'hFFFF);
      queue_free(16'd65512);          // aligned, never handed out
      queue_alloc(16'd2049);          // pops the freed 4k block
      queue_alloc(16'd4089);
      queue_alloc(16'hFFFF);
      queue_free(live_addrs[0]);

      for (int n = 0; n < 1430; n++) begin
         steady = (n >= 900 && n < 1150);
         if (n == 700) begin
            drain_results();
         end
         pick = $urandom_range(99);
         if (pick < 3) begin
            queue_alloc(16'($urandom_range(65535)));
         end else if (pick < 6) begin
            queue_free(16'($urandom_range(65535)));
         end else begin
            free_pct = (live_addrs.size() > 40) ? 70 : ((live_addrs.size() < 6) ? 15 : 45);
            if (live_addrs.size() != 0 && $urandom_range(99) < free_pct) begin
               queue_free(live_addrs[$urandom_range(live_addrs.size() - 1)]);
            end else begin
               // small classes more often, they carve many blocks per chunk
               cls = $urandom_range(1) ? MIN_LOG2 + $urandom_range(7)
                                       : MIN_LOG2 + $urandom_range(3);
               lo = (cls == MIN_LOG2) ? 0 : (1 << (cls - 1)) - 7;
               hi = (1 << cls) - 8;
               queue_alloc(16'($urandom_range(hi, lo)));
            end
         end
      end
      steady = 1'b0;

      drain_results();
      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
